@@ rtl/depth_pixel_backprojection_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Depth pixel back-projection: assertion macros
// Shared property macros for the checker of the back-projection unit.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while the given condition is true.
`define DPB_ASSERT_IMPL(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the given condition is true.
`define DPB_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dpb_pkg.sv @@
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Register indexes, reset values and fixed field widths of the unit.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Default width of the pixel row and column inputs.
  localparam int COORD_WIDTH_DEF = 12;

  // Fixed field widths.
  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int CENTER_W = 16;
  localparam int RECIP_W  = 32;
  localparam int POINT_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Pixel coordinates are compared with the principal point in 1/16 pixel.
  localparam int SUBPIX_BITS = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_COL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_ROW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DEPTH_SCALE = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [CENTER_W-1:0] CENTER_COL_RST      = 16'd5112;
  localparam logic [CENTER_W-1:0] CENTER_ROW_RST      = 16'd3832;
  localparam logic [RECIP_W-1:0]  INV_FOCAL_COL_RST   = 32'd8181091;
  localparam logic [RECIP_W-1:0]  INV_FOCAL_ROW_RST   = 32'd8181091;
  localparam logic [RECIP_W-1:0]  INV_DEPTH_SCALE_RST = 32'd4294967;

  // Raw depth code that means no measurement.
  localparam logic [DEPTH_W-1:0] NO_DEPTH = '0;

  // Saturation limits of the lateral coordinates.
  localparam logic [POINT_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [POINT_W-1:0] NEG_LIMIT = 32'h8000_0000;

endpackage

@@ rtl/depth_pixel_backprojection_unit.sv @@
// ----------------------------------------------------------------------------
// Depth pixel back-projection unit
// Turns depth pixels into colored Q16.16 points with a pinhole camera model.
// ----------------------------------------------------------------------------
// Use:
//   The input channel carries one pixel per request: raw depth, BGR color
//   and its row and column. Pixels with an odd row or column, or with zero
//   depth, are dropped inside the unit and give no output request. Every
//   other pixel gives one point: x and y signed, z unsigned, all Q16.16.
//   Both channels use valid and stall; a request moves when valid is high
//   and stall is low.
//   Throughput is one pixel per cycle while the receiver does not stall;
//   the four register stages (offsets and depth scale, reciprocal focal
//   length, two partial products, final sum and saturation) each hold
//   one pixel.
//   The user must write the camera registers through the cfg port only
//   while no pixel is in flight; the unit does not enforce this. Reset
//   loads the default camera and empties the pipeline. When the receiver
//   stalls, the point is held on the output and the stages behind it keep
//   filling any empty slot; in_stall rises only when all four are full.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit
  import dpb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Pixel input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [DEPTH_W-1:0]     in_depth_raw,
  input  logic [COLOR_W-1:0]     in_blue,
  input  logic [COLOR_W-1:0]     in_green,
  input  logic [COLOR_W-1:0]     in_red,
  input  logic [COORD_WIDTH-1:0] in_pix_row,
  input  logic [COORD_WIDTH-1:0] in_pix_col,
  // Point output channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [POINT_W-1:0]     out_point_x,
  output logic [POINT_W-1:0]     out_point_y,
  output logic [POINT_W-1:0]     out_point_z,
  output logic [COLOR_W-1:0]     out_point_blue,
  output logic [COLOR_W-1:0]     out_point_green,
  output logic [COLOR_W-1:0]     out_point_red
);

  // Magnitude of a pixel offset from the principal point, 1/16 pixel units.
  localparam int SHIFT_W = COORD_WIDTH + SUBPIX_BITS;
  localparam int MAG_W   = (SHIFT_W > CENTER_W) ? SHIFT_W : CENTER_W;
  localparam int DIFF_W  = MAG_W + 1;
  localparam int ZPROD_W = DEPTH_W + RECIP_W;
  localparam int T_W     = POINT_W + RECIP_W;
  localparam int PROD_W  = MAG_W + 32;
  localparam int SUM_W   = PROD_W + 1;
  localparam int M_W     = SUM_W - 4;

  // Camera registers.
  logic [CENTER_W-1:0] center_col_r;
  logic [CENTER_W-1:0] center_row_r;
  logic [RECIP_W-1:0]  inv_focal_col_r;
  logic [RECIP_W-1:0]  inv_focal_row_r;
  logic [RECIP_W-1:0]  inv_depth_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r      <= CENTER_COL_RST;
      center_row_r      <= CENTER_ROW_RST;
      inv_focal_col_r   <= INV_FOCAL_COL_RST;
      inv_focal_row_r   <= INV_FOCAL_ROW_RST;
      inv_depth_scale_r <= INV_DEPTH_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_COL:      center_col_r      <= cfg_wdata[CENTER_W-1:0];
        REG_CENTER_ROW:      center_row_r      <= cfg_wdata[CENTER_W-1:0];
        REG_INV_FOCAL_COL:   inv_focal_col_r   <= cfg_wdata[RECIP_W-1:0];
        REG_INV_FOCAL_ROW:   inv_focal_row_r   <= cfg_wdata[RECIP_W-1:0];
        REG_INV_DEPTH_SCALE: inv_depth_scale_r <= cfg_wdata[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain. A stage takes a new request when
  // it is empty or when its own content moves on in the same cycle.
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready = !s4_valid_r || !out_stall;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  // Only even rows and columns with a real measurement make a point.
  logic keep;
  assign keep = !in_pix_row[0] && !in_pix_col[0] && (in_depth_raw != NO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid && keep;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
      if (s4_ready) s4_valid_r <= s3_valid_r;
    end
  end

  // Stage 1: offsets from the principal point and the depth scaling product.
  logic [DIFF_W-1:0]  col_diff, row_diff, col_abs, row_abs;
  logic [MAG_W-1:0]   col_mag_nxt, row_mag_nxt;
  logic [ZPROD_W-1:0] zprod_nxt;

  always_comb begin
    col_diff = {{(DIFF_W-SHIFT_W){1'b0}}, in_pix_col, {SUBPIX_BITS{1'b0}}}
             - {{(DIFF_W-CENTER_W){1'b0}}, center_col_r};
    row_diff = {{(DIFF_W-SHIFT_W){1'b0}}, in_pix_row, {SUBPIX_BITS{1'b0}}}
             - {{(DIFF_W-CENTER_W){1'b0}}, center_row_r};
    col_abs  = col_diff[DIFF_W-1] ? (~col_diff + {{(DIFF_W-1){1'b0}}, 1'b1}) : col_diff;
    row_abs  = row_diff[DIFF_W-1] ? (~row_diff + {{(DIFF_W-1){1'b0}}, 1'b1}) : row_diff;
    col_mag_nxt = col_abs[MAG_W-1:0];
    row_mag_nxt = row_abs[MAG_W-1:0];
    zprod_nxt   = {{RECIP_W{1'b0}}, in_depth_raw} * {{DEPTH_W{1'b0}}, inv_depth_scale_r};
  end

  logic [MAG_W-1:0]   s1_col_mag_r, s1_row_mag_r;
  logic               s1_col_neg_r, s1_row_neg_r;
  logic [ZPROD_W-1:0] s1_zprod_r;
  logic [COLOR_W-1:0] s1_blue_r, s1_green_r, s1_red_r;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_col_mag_r <= col_mag_nxt;
      s1_row_mag_r <= row_mag_nxt;
      s1_col_neg_r <= col_diff[DIFF_W-1];
      s1_row_neg_r <= row_diff[DIFF_W-1];
      s1_zprod_r   <= zprod_nxt;
      s1_blue_r    <= in_blue;
      s1_green_r   <= in_green;
      s1_red_r     <= in_red;
    end
  end

  // Stage 2: z in Q16.16 and its products with the focal reciprocals.
  // The scaled depth always fits 32 bits, so z never needs to saturate.
  logic [POINT_W-1:0] z_nxt;
  logic [T_W-1:0]     t_col_nxt, t_row_nxt;

  always_comb begin
    z_nxt     = s1_zprod_r[ZPROD_W-1:DEPTH_W];
    t_col_nxt = {{RECIP_W{1'b0}}, z_nxt} * {{POINT_W{1'b0}}, inv_focal_col_r};
    t_row_nxt = {{RECIP_W{1'b0}}, z_nxt} * {{POINT_W{1'b0}}, inv_focal_row_r};
  end

  logic [MAG_W-1:0]   s2_col_mag_r, s2_row_mag_r;
  logic               s2_col_neg_r, s2_row_neg_r;
  logic [POINT_W-1:0] s2_z_r;
  logic [T_W-1:0]     s2_t_col_r, s2_t_row_r;
  logic [COLOR_W-1:0] s2_blue_r, s2_green_r, s2_red_r;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_col_mag_r <= s1_col_mag_r;
      s2_row_mag_r <= s1_row_mag_r;
      s2_col_neg_r <= s1_col_neg_r;
      s2_row_neg_r <= s1_row_neg_r;
      s2_z_r       <= z_nxt;
      s2_t_col_r   <= t_col_nxt;
      s2_t_row_r   <= t_row_nxt;
      s2_blue_r    <= s1_blue_r;
      s2_green_r   <= s1_green_r;
      s2_red_r     <= s1_red_r;
    end
  end

  // Stage 3: offset magnitude times the low and high halves of z * inv.
  logic [PROD_W-1:0] col_lo_nxt, col_hi_nxt, row_lo_nxt, row_hi_nxt;

  always_comb begin
    col_lo_nxt = {{32{1'b0}}, s2_col_mag_r} * {{MAG_W{1'b0}}, s2_t_col_r[31:0]};
    col_hi_nxt = {{32{1'b0}}, s2_col_mag_r} * {{MAG_W{1'b0}}, s2_t_col_r[T_W-1:32]};
    row_lo_nxt = {{32{1'b0}}, s2_row_mag_r} * {{MAG_W{1'b0}}, s2_t_row_r[31:0]};
    row_hi_nxt = {{32{1'b0}}, s2_row_mag_r} * {{MAG_W{1'b0}}, s2_t_row_r[T_W-1:32]};
  end

  logic [PROD_W-1:0]  s3_col_lo_r, s3_col_hi_r, s3_row_lo_r, s3_row_hi_r;
  logic               s3_col_neg_r, s3_row_neg_r;
  logic [POINT_W-1:0] s3_z_r;
  logic [COLOR_W-1:0] s3_blue_r, s3_green_r, s3_red_r;

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_col_lo_r  <= col_lo_nxt;
      s3_col_hi_r  <= col_hi_nxt;
      s3_row_lo_r  <= row_lo_nxt;
      s3_row_hi_r  <= row_hi_nxt;
      s3_col_neg_r <= s2_col_neg_r;
      s3_row_neg_r <= s2_row_neg_r;
      s3_z_r       <= s2_z_r;
      s3_blue_r    <= s2_blue_r;
      s3_green_r   <= s2_green_r;
      s3_red_r     <= s2_red_r;
    end
  end

  // Combine the partial products into |product| >> 36, restore the sign
  // and saturate to the signed 32-bit range.
  function automatic logic [POINT_W-1:0] lateral(input logic [PROD_W-1:0] lo,
                                                 input logic [PROD_W-1:0] hi,
                                                 input logic              neg);
    logic [SUM_W-1:0] sum;
    logic [M_W-1:0]   mag;
    logic             over;
    sum  = {1'b0, hi} + {{(SUM_W-MAG_W){1'b0}}, lo[PROD_W-1:32]};
    mag  = sum[SUM_W-1:4];
    over = |mag[M_W-1:31];
    if (over) begin
      lateral = neg ? NEG_LIMIT : POS_LIMIT;
    end else if (neg) begin
      lateral = ~mag[POINT_W-1:0] + {{(POINT_W-1){1'b0}}, 1'b1};
    end else begin
      lateral = mag[POINT_W-1:0];
    end
  endfunction

  // Stage 4: output register.
  logic [POINT_W-1:0] x_nxt, y_nxt;

  always_comb begin
    x_nxt = lateral(s3_col_lo_r, s3_col_hi_r, s3_col_neg_r);
    y_nxt = lateral(s3_row_lo_r, s3_row_hi_r, s3_row_neg_r);
  end

  logic [POINT_W-1:0] s4_x_r, s4_y_r, s4_z_r;
  logic [COLOR_W-1:0] s4_blue_r, s4_green_r, s4_red_r;

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_x_r     <= x_nxt;
      s4_y_r     <= y_nxt;
      s4_z_r     <= s3_z_r;
      s4_blue_r  <= s3_blue_r;
      s4_green_r <= s3_green_r;
      s4_red_r   <= s3_red_r;
    end
  end

  assign out_valid       = s4_valid_r;
  assign out_point_x     = s4_x_r;
  assign out_point_y     = s4_y_r;
  assign out_point_z     = s4_z_r;
  assign out_point_blue  = s4_blue_r;
  assign out_point_green = s4_green_r;
  assign out_point_red   = s4_red_r;

endmodule

@@ rtl/dpb_checker.sv @@
// ----------------------------------------------------------------------------
// Depth pixel back-projection checker
// Port-level properties of the back-projection unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "depth_pixel_backprojection_unit_defines.svh"

module dpb_checker
  import dpb_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [POINT_W-1:0] out_point_x,
  input logic [POINT_W-1:0] out_point_y,
  input logic [POINT_W-1:0] out_point_z,
  input logic [COLOR_W-1:0] out_point_blue,
  input logic [COLOR_W-1:0] out_point_green,
  input logic [COLOR_W-1:0] out_point_red
);

  // A stalled point stays on the output unchanged.
  `DPB_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && out_stall,
    out_valid && $stable(out_point_x) && $stable(out_point_y) &&
    $stable(out_point_z) && $stable(out_point_blue) &&
    $stable(out_point_green) && $stable(out_point_red),
    "stalled output point changed")

  // The input can only back up when the output is full and stalled.
  `DPB_ASSERT_IMPL(a_stall_chain, clk, !rst_n, in_stall,
    out_valid && out_stall, "input stalled while output can drain")

  // A point at zero depth lies on the optical axis.
  `DPB_ASSERT_IMPL(a_zero_depth_axis, clk, !rst_n, out_valid && (out_point_z == '0),
    (out_point_x == '0) && (out_point_y == '0), "zero depth point off axis")

  // Reset empties the pipeline.
  `DPB_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid,
    "output valid right after reset")

endmodule

bind depth_pixel_backprojection_unit dpb_checker u_dpb_checker (.*);

@@ tb/sv/dpb_point_checker.sv @@
// ----------------------------------------------------------------------------
// Depth pixel back-projection: point checker
// Watches the camera register writes and both channels of the unit. Every
// accepted pixel that should yield a point has its expected point computed
// and queued. Every point that leaves the unit is compared with the oldest
// queued point.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dpb_point_checker
  import dpb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [DEPTH_W-1:0]     in_depth_raw,
  input  logic [COLOR_W-1:0]     in_blue,
  input  logic [COLOR_W-1:0]     in_green,
  input  logic [COLOR_W-1:0]     in_red,
  input  logic [COORD_WIDTH-1:0] in_pix_row,
  input  logic [COORD_WIDTH-1:0] in_pix_col,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [POINT_W-1:0]     out_point_x,
  input  logic [POINT_W-1:0]     out_point_y,
  input  logic [POINT_W-1:0]     out_point_z,
  input  logic [COLOR_W-1:0]     out_point_blue,
  input  logic [COLOR_W-1:0]     out_point_green,
  input  logic [COLOR_W-1:0]     out_point_red,
  output int                     mismatch_count,
  output int                     points_pending
);

  typedef struct packed {
    logic [POINT_W-1:0] x;
    logic [POINT_W-1:0] y;
    logic [POINT_W-1:0] z;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } point_t;

  // Local copy of the camera registers.
  logic [CENTER_W-1:0] cam_center_col;
  logic [CENTER_W-1:0] cam_center_row;
  logic [RECIP_W-1:0]  cam_inv_focal_col;
  logic [RECIP_W-1:0]  cam_inv_focal_row;
  logic [RECIP_W-1:0]  cam_inv_depth_scale;

  // Points owed by the unit, oldest first.
  point_t expected_points[$];

  // Offset from the principal point times depth times the reciprocal focal
  // length, scaled down by 2^36 toward zero and saturated to 32 bits.
  function automatic logic [POINT_W-1:0] lateral_offset(
    input logic [COORD_WIDTH-1:0] pix,
    input logic [CENTER_W-1:0]    center,
    input logic [POINT_W-1:0]     depth_z,
    input logic [RECIP_W-1:0]     recip
  );
    logic signed [21:0] offset;
    logic [21:0]        mag;
    logic [95:0]        prod;
    logic [59:0]        scaled;
    offset = $signed(22'(pix) << SUBPIX_BITS) - $signed(22'(center));
    mag    = offset[21] ? 22'(-offset) : 22'(offset);
    prod   = 96'(mag) * 96'(64'(depth_z) * 64'(recip));
    scaled = prod[95:36];
    if (offset[21]) begin
      if (scaled >= 60'h8000_0000) return NEG_LIMIT;
      return -scaled[31:0];
    end
    if (scaled > 60'h7FFF_FFFF) return POS_LIMIT;
    return scaled[31:0];
  endfunction

  // Full point for one accepted pixel under the current camera.
  function automatic point_t project_point(
    input logic [DEPTH_W-1:0]     depth,
    input logic [COLOR_W-1:0]     blue,
    input logic [COLOR_W-1:0]     green,
    input logic [COLOR_W-1:0]     red,
    input logic [COORD_WIDTH-1:0] row,
    input logic [COORD_WIDTH-1:0] col
  );
    logic [47:0] depth_scaled;
    point_t      pt;
    depth_scaled = 48'(depth) * 48'(cam_inv_depth_scale);
    pt.z     = depth_scaled[47:16];
    pt.x     = lateral_offset(col, cam_center_col, pt.z, cam_inv_focal_col);
    pt.y     = lateral_offset(row, cam_center_row, pt.z, cam_inv_focal_row);
    pt.blue  = blue;
    pt.green = green;
    pt.red   = red;
    return pt;
  endfunction

  // Register tracking, point comparison and prediction, all at the edge.
  always @(posedge clk) begin
    point_t want;
    point_t got;
    point_t next_pt;
    if (!rst_n) begin
      cam_center_col      = CENTER_COL_RST;
      cam_center_row      = CENTER_ROW_RST;
      cam_inv_focal_col   = INV_FOCAL_COL_RST;
      cam_inv_focal_row   = INV_FOCAL_ROW_RST;
      cam_inv_depth_scale = INV_DEPTH_SCALE_RST;
      expected_points.delete();
      mismatch_count <= 0;
    end else begin
      // Camera register writes; unknown indexes are ignored.
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_COL:      cam_center_col      = cfg_wdata[CENTER_W-1:0];
          REG_CENTER_ROW:      cam_center_row      = cfg_wdata[CENTER_W-1:0];
          REG_INV_FOCAL_COL:   cam_inv_focal_col   = cfg_wdata[RECIP_W-1:0];
          REG_INV_FOCAL_ROW:   cam_inv_focal_row   = cfg_wdata[RECIP_W-1:0];
          REG_INV_DEPTH_SCALE: cam_inv_depth_scale = cfg_wdata[RECIP_W-1:0];
          default: ;
        endcase
      end

      // A point leaving the unit is matched against the oldest expectation.
      if (out_valid && !out_stall) begin
        got = {out_point_x, out_point_y, out_point_z,
               out_point_blue, out_point_green, out_point_red};
        if (expected_points.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected point: x=%0d y=%0d z=%0d bgr=%0d/%0d/%0d",
                     $signed(got.x), $signed(got.y), got.z,
                     got.blue, got.green, got.red);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("point mismatch: expected x=%0d y=%0d z=%0d bgr=%0d/%0d/%0d",
                       $signed(want.x), $signed(want.y), want.z,
                       want.blue, want.green, want.red);
              $display("                actual   x=%0d y=%0d z=%0d bgr=%0d/%0d/%0d",
                       $signed(got.x), $signed(got.y), got.z,
                       got.blue, got.green, got.red);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end

      // Only even rows and columns with a depth measurement give a point.
      if (in_valid && !in_stall && !in_pix_row[0] && !in_pix_col[0] &&
          in_depth_raw != NO_DEPTH) begin
        next_pt = project_point(in_depth_raw, in_blue, in_green,
                                in_red, in_pix_row, in_pix_col);
        expected_points = {expected_points, next_pt};
      end
    end
    points_pending <= expected_points.size();
  end

endmodule

@@ tb/sv/depth_pixel_backprojection_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Depth pixel back-projection unit testbench
// Drives pixel requests through the unit under several camera settings,
// first a short directed set of corner pixels, then random pixels with
// random idle and stall bursts. The point checker predicts and compares
// every point; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module depth_pixel_backprojection_unit_tb;
  import dpb_pkg::*;

  localparam int PIX_W = COORD_WIDTH_DEF;
  // Register index outside the camera register list.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // Pipeline latency plus margin, waited out before any register write.
  localparam int DRAIN_CYCLES = 10;
  // Cycles without any accepted request before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int POINTS_PER_PHASE = 60;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [DEPTH_W-1:0]    in_depth_raw;
  logic [COLOR_W-1:0]    in_blue;
  logic [COLOR_W-1:0]    in_green;
  logic [COLOR_W-1:0]    in_red;
  logic [PIX_W-1:0]      in_pix_row;
  logic [PIX_W-1:0]      in_pix_col;
  logic                  out_valid;
  logic                  out_stall;
  logic [POINT_W-1:0]    out_point_x;
  logic [POINT_W-1:0]    out_point_y;
  logic [POINT_W-1:0]    out_point_z;
  logic [COLOR_W-1:0]    out_point_blue;
  logic [COLOR_W-1:0]    out_point_green;
  logic [COLOR_W-1:0]    out_point_red;
  int                    mismatch_count;
  int                    points_pending;
  int                    quiet_cycles;
  bit                    calm_tail;

  depth_pixel_backprojection_unit #(
    .COORD_WIDTH(PIX_W)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_depth_raw   (in_depth_raw),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .in_pix_row     (in_pix_row),
    .in_pix_col     (in_pix_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_point_blue (out_point_blue),
    .out_point_green(out_point_green),
    .out_point_red  (out_point_red)
  );

  dpb_point_checker #(
    .COORD_WIDTH(PIX_W)
  ) u_checker (.*);

  // Clock, 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver side: random stall bursts, none once the calm tail begins.
  initial begin
    int run_len;
    int stall_len;
    out_stall = 1'b0;
    forever begin
      run_len = $urandom_range(1, 40);
      repeat (run_len) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
      if (!calm_tail && $urandom_range(0, 1) == 1) begin
        stall_len = $urandom_range(1, 18);
        repeat (stall_len) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One pixel request, held until accepted, sometimes after an idle burst.
  task automatic send_pixel(input logic [DEPTH_W-1:0] depth,
                            input logic [COLOR_W-1:0] blue,
                            input logic [COLOR_W-1:0] green,
                            input logic [COLOR_W-1:0] red,
                            input logic [PIX_W-1:0]   row,
                            input logic [PIX_W-1:0]   col);
    int gap;
    if (!calm_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_depth_raw <= depth;
    in_blue      <= blue;
    in_green     <= green;
    in_red       <= red;
    in_pix_row   <= row;
    in_pix_col   <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drives one register write; the caller lowers the write enable.
  task automatic drive_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_camera(input logic [CFG_DATA_W-1:0] center_col,
                             input logic [CFG_DATA_W-1:0] center_row,
                             input logic [CFG_DATA_W-1:0] inv_fx,
                             input logic [CFG_DATA_W-1:0] inv_fy,
                             input logic [CFG_DATA_W-1:0] inv_scale);
    drive_reg(REG_CENTER_COL, center_col);
    drive_reg(REG_CENTER_ROW, center_row);
    drive_reg(REG_INV_FOCAL_COL, inv_fx);
    drive_reg(REG_INV_FOCAL_ROW, inv_fy);
    drive_reg(REG_INV_DEPTH_SCALE, inv_scale);
    cfg_we <= 1'b0;
  endtask

  // Stops requests and waits until every owed point has come out and any
  // dropped pixels have left the pipeline.
  task automatic drain_pipeline;
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Reciprocal register value: full range, a realistic camera, or tiny.
  function automatic logic [RECIP_W-1:0] pick_recip;
    case ($urandom_range(0, 2))
      0:       return RECIP_W'($urandom);
      1:       return RECIP_W'($urandom_range(2_000_000, 22_000_000));
      default: return RECIP_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // Random pixels until the requested number of point-producing pixels has
  // gone in; some odd, zero-depth and noise pixels are mixed in.
  task automatic send_random_pixels(input int point_goal);
    int               points_sent;
    int               kind;
    logic [DEPTH_W-1:0] depth;
    logic [PIX_W-1:0]   row;
    logic [PIX_W-1:0]   col;
    points_sent = 0;
    while (points_sent < point_goal) begin
      kind  = $urandom_range(0, 9);
      depth = DEPTH_W'($urandom);
      row   = PIX_W'($urandom);
      col   = PIX_W'($urandom);
      if (kind < 7) begin
        row[0] = 1'b0;
        col[0] = 1'b0;
        if (kind < 2) depth = DEPTH_W'($urandom_range(1, 255));
        if (depth == NO_DEPTH) depth = 1;
      end else if (kind == 7) begin
        depth = NO_DEPTH;
      end
      if (!row[0] && !col[0] && depth != NO_DEPTH) points_sent++;
      send_pixel(depth, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                 row, col);
    end
  endtask

  // Main sequence: reset, directed pixels, random camera phases, verdict.
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_depth_raw = '0;
    in_blue      = '0;
    in_green     = '0;
    in_red       = '0;
    in_pix_row   = '0;
    in_pix_col   = '0;
    calm_tail    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default camera: field extremes, odd coordinates and missing depth.
    send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd0);
    send_pixel(16'd1, 8'h00, 8'h00, 8'h00, 12'd4094, 12'd4094);
    send_pixel(16'd1234, 8'hAA, 8'h55, 8'h0F, 12'd240, 12'd320);
    send_pixel(16'd500, 8'h12, 8'h34, 8'h56, 12'd2, 12'd3);
    send_pixel(16'd500, 8'h12, 8'h34, 8'h56, 12'd3, 12'd2);
    send_pixel(NO_DEPTH, 8'h01, 8'h02, 8'h03, 12'd10, 12'd10);
    send_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hFF, 12'd4095, 12'd4095);
    send_pixel(16'h8000, 8'h80, 8'h7F, 8'h01, 12'h800, 12'h7FE);

    // Principal point at the origin with the largest reciprocals: positive
    // saturation far from the center, zero offset at the center.
    drain_pipeline();
    load_camera(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(16'hFFFF, 8'h11, 8'h22, 8'h33, 12'd4094, 12'd4094);
    send_pixel(16'hFFFF, 8'h44, 8'h55, 8'h66, 12'd0, 12'd0);
    send_pixel(16'd1, 8'h77, 8'h88, 8'h99, 12'd2, 12'd2);

    // Principal point at the far corner: negative saturation.
    drain_pipeline();
    load_camera(32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
    send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'h00, 12'd0, 12'd0);
    send_pixel(16'd1, 8'h00, 8'hFF, 8'hFF, 12'd4094, 12'd4094);

    // Zero reciprocals give an all-zero point; a write beyond the register
    // list must leave the camera untouched.
    drain_pipeline();
    drive_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    load_camera(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 32'd0, 32'd0, 32'd0);
    send_pixel(16'hFFFF, 8'h5A, 8'hA5, 8'h3C, 12'd100, 12'd4000);
    send_pixel(16'd7, 8'hC3, 8'h3C, 8'h5A, 12'd4000, 12'd100);

    // Tiny depth scale: nonzero depth whose z truncates to zero.
    drain_pipeline();
    load_camera(32'd5112, 32'd3832, 32'd8181091, 32'd8181091, 32'd1);
    send_pixel(16'hFFFF, 8'h10, 8'h20, 8'h30, 12'd0, 12'd4094);
    send_pixel(16'd1, 8'h40, 8'h50, 8'h60, 12'd4094, 12'd0);

    // Random cameras with random pixels; the last phase runs without idling.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_pipeline();
      if (phase == RANDOM_PHASES - 1) calm_tail = 1'b1;
      load_camera(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), pick_recip(),
                  pick_recip(), pick_recip());
      send_random_pixels(POINTS_PER_PHASE);
    end

    drain_pipeline();
    if (mismatch_count == 0 && points_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dpb_pkg.sv
rtl/depth_pixel_backprojection_unit.sv
rtl/dpb_checker.sv
tb/sv/dpb_point_checker.sv
tb/sv/depth_pixel_backprojection_unit_tb.sv
